>>> hw/rtl/word_wrap_row_breaker_macros.svh
// ----------------------------------------------------------------------------
// word wrap row breaker assertion macros
// Shared property forms for the checker; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef WORD_WRAP_ROW_BREAKER_MACROS_SVH
`define WORD_WRAP_ROW_BREAKER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define WWRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define WWRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wwrb_pkg.sv
// ----------------------------------------------------------------------------
// wwrb_pkg
// Constants, types and helper functions shared by the row breaker files.
// ----------------------------------------------------------------------------
package wwrb_pkg;

  // tab stop spacing and offset saturation width
  localparam int TAB_STOP    = 4;
  localparam int OFFSET_BITS = 16;

  // field and state widths
  localparam int OFF_W   = 16;
  localparam int COL_W   = 16;
  localparam int ROWW_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int PHASE_W = $clog2(TAB_STOP + 1);

  // offsets saturate at the smaller of the offset range and the state width
  localparam int CAP_BITS = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
  localparam logic [OFF_W-1:0] OFFSET_CAP = OFF_W'((64'd1 << CAP_BITS) - 64'd1);
  localparam logic [COL_W-1:0] COLUMN_CAP = {COL_W{1'b1}};

  // byte classes
  localparam logic [BYTE_W-1:0] BYTE_CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] BYTE_CONT_CODE = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_SPACE     = 8'h20;

  // request commands
  localparam logic CMD_LINE_START = 1'b0;
  localparam logic CMD_TEXT       = 1'b1;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_WRAP_ENABLE = 1'b0;
  localparam logic REG_ROW_WIDTH   = 1'b1;
  localparam logic [ROWW_W-1:0] ROW_WIDTH_RESET = 10'd80;

  typedef struct packed {
    logic              wrap_enable;
    logic [ROWW_W-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] byte_value;
  } item_t;

  // up to two row starts produced by one request
  typedef struct packed {
    logic             push;
    logic [1:0]       count;
    logic [OFF_W-1:0] first;
    logic [OFF_W-1:0] second;
  } res_t;

  function automatic logic [OFF_W-1:0] clip_offset(input logic [OFF_W:0] v);
    return (v > {1'b0, OFFSET_CAP}) ? OFFSET_CAP : v[OFF_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] clip_column(input logic [COL_W:0] v);
    return v[COL_W] ? COLUMN_CAP : v[COL_W-1:0];
  endfunction

  // columns used from the row base would exceed the row width
  function automatic logic overflows(input logic [COL_W-1:0]  next_col,
                                     input logic [COL_W-1:0]  base_col,
                                     input logic [ROWW_W-1:0] width);
    logic [COL_W-1:0] used;
    used = (next_col >= base_col) ? (next_col - base_col) : '0;
    return used > {{(COL_W-ROWW_W){1'b0}}, width};
  endfunction

endpackage

>>> hw/rtl/wwrb_if.sv
// ----------------------------------------------------------------------------
// wwrb channel interfaces
// Valid/ready channels for text byte requests and row start results.
// ----------------------------------------------------------------------------

// text byte request channel
interface wwrb_in_if;
  import wwrb_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

// row start result channel
interface wwrb_out_if;
  import wwrb_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] row_start;
  logic             last_of_run;

  modport source (output valid, output row_start, output last_of_run, input ready);
  modport sink   (input valid, input row_start, input last_of_run, output ready);
endinterface

>>> hw/rtl/wwrb_cfg.sv
// ----------------------------------------------------------------------------
// wwrb_cfg
// APB-style register block holding the wrap enable and the row width.
// ----------------------------------------------------------------------------
module wwrb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wwrb_pkg::PADDR_W-1:0]  paddr,
  input  logic [wwrb_pkg::PDATA_W-1:0]  pwdata,
  output logic [wwrb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output wwrb_pkg::cfg_t                cfg
);
  import wwrb_pkg::*;

  logic              wrap_enable_r, wrap_enable_nxt;
  logic [ROWW_W-1:0] row_width_r, row_width_nxt;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    wrap_enable_nxt = wrap_enable_r;
    row_width_nxt   = row_width_r;
    if (wr_en) begin
      case (reg_sel)
        REG_WRAP_ENABLE: wrap_enable_nxt = pwdata[0];
        REG_ROW_WIDTH:   row_width_nxt   = pwdata[ROWW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_enable_r <= 1'b0;
      row_width_r   <= ROW_WIDTH_RESET;
    end else begin
      wrap_enable_r <= wrap_enable_nxt;
      row_width_r   <= row_width_nxt;
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_WRAP_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, wrap_enable_r};
      REG_ROW_WIDTH:   prdata = {{(PDATA_W-ROWW_W){1'b0}}, row_width_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.wrap_enable = wrap_enable_r;
  assign cfg.row_width   = row_width_r;

endmodule

>>> hw/rtl/wwrb_core.sv
// ----------------------------------------------------------------------------
// wwrb_core
// Request register, line state and single pass break decision per byte.
// ----------------------------------------------------------------------------
module wwrb_core (
  input  logic            clk,
  input  logic            rst_n,
  input  wwrb_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  wwrb_pkg::item_t in_item,
  output logic            in_ready,
  input  logic            q_free,
  output wwrb_pkg::res_t  res
);
  import wwrb_pkg::*;

  // request register
  logic  item_valid_r, item_valid_nxt;
  item_t item_r;
  logic  advance;

  // line state
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [COL_W-1:0]   base_r, base_nxt;
  logic [OFF_W-1:0]   rbo_r, rbo_nxt;
  logic [OFF_W-1:0]   aso_r, aso_nxt;
  logic [COL_W-1:0]   asc_r, asc_nxt;

  // decision terms
  logic               is_cont, is_tab, is_space, wrapping;
  logic [OFF_W-1:0]   off_inc;
  logic [COL_W:0]     col_step;
  logic [COL_W-1:0]   next_col;
  logic [PHASE_W-1:0] phase_step;
  logic               ov_row, ov_space;

  assign advance  = item_valid_r & q_free;
  assign in_ready = ~item_valid_r | advance;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_ready) begin
      item_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  // byte classification and column advance
  assign is_cont  = (item_r.byte_value & BYTE_CONT_MASK) == BYTE_CONT_CODE;
  assign is_tab   = item_r.byte_value == BYTE_TAB;
  assign is_space = item_r.byte_value == BYTE_SPACE;
  assign wrapping = cfg.wrap_enable && (cfg.row_width != '0);
  assign off_inc  = clip_offset({1'b0, off_r} + (OFF_W+1)'(1));

  // phase tracks the column within a tab stop until the column saturates
  assign col_step = is_tab ? (COL_W+1)'(TAB_STOP - 32'(phase_r)) : (COL_W+1)'(1);
  assign next_col = clip_column({1'b0, col_r} + col_step);
  assign phase_step = (32'(phase_r) == TAB_STOP - 1) ? '0 : phase_r + PHASE_W'(1);

  assign ov_row   = overflows(next_col, base_r, cfg.row_width);
  assign ov_space = overflows(next_col, asc_r, cfg.row_width);

  // break decision, second check after a break at a space folded in
  always_comb begin
    off_nxt    = off_r;
    col_nxt    = col_r;
    phase_nxt  = phase_r;
    base_nxt   = base_r;
    rbo_nxt    = rbo_r;
    aso_nxt    = aso_r;
    asc_nxt    = asc_r;
    res.push   = advance;
    res.count  = 2'd0;
    res.first  = '0;
    res.second = '0;
    if (advance) begin
      if (item_r.command == CMD_LINE_START) begin
        off_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = '0;
        base_nxt  = '0;
        rbo_nxt   = '0;
        aso_nxt   = '0;
        asc_nxt   = '0;
        res.count = 2'd1;
      end else if (is_cont) begin
        off_nxt = off_inc;
      end else begin
        if (wrapping && ov_row && (off_r > rbo_r)) begin
          if (aso_r > rbo_r) begin
            res.first = aso_r;
            res.count = 2'd1;
            rbo_nxt   = aso_r;
            base_nxt  = asc_r;
            aso_nxt   = '0;
            if (ov_space && (off_r > aso_r)) begin
              res.second = off_r;
              res.count  = 2'd2;
              rbo_nxt    = off_r;
              base_nxt   = col_r;
            end
          end else begin
            res.first = off_r;
            res.count = 2'd1;
            rbo_nxt   = off_r;
            base_nxt  = col_r;
            aso_nxt   = '0;
          end
        end
        if (is_space) begin
          aso_nxt = off_inc;
          asc_nxt = clip_column({1'b0, col_r} + (COL_W+1)'(1));
        end
        col_nxt   = next_col;
        phase_nxt = is_tab ? '0 : phase_step;
        off_nxt   = off_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      col_r   <= '0;
      phase_r <= '0;
      base_r  <= '0;
      rbo_r   <= '0;
      aso_r   <= '0;
      asc_r   <= '0;
    end else begin
      off_r   <= off_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      rbo_r   <= rbo_nxt;
      aso_r   <= aso_nxt;
      asc_r   <= asc_nxt;
    end
  end

endmodule

>>> hw/rtl/wwrb_outq.sv
// ----------------------------------------------------------------------------
// wwrb_outq
// Two-entry result register that hands out the row starts of one request.
// ----------------------------------------------------------------------------
module wwrb_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wwrb_pkg::res_t            res,
  output logic                      q_free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [wwrb_pkg::OFF_W-1:0] row_start,
  output logic                      last_of_run
);
  import wwrb_pkg::*;

  logic [1:0]       count_r, count_nxt;
  logic [OFF_W-1:0] head_r, head_nxt;
  logic [OFF_W-1:0] tail_r, tail_nxt;
  logic             pop;

  assign out_valid   = count_r != 2'd0;
  assign pop         = out_valid & out_ready;
  assign row_start   = head_r;
  assign last_of_run = count_r == 2'd1;

  // new results only enter once the queue drains this cycle
  assign q_free = (count_r == 2'd0) || ((count_r == 2'd1) && out_ready);

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (res.push) begin
      count_nxt = res.count;
      head_nxt  = res.first;
      tail_nxt  = res.second;
    end else if (pop) begin
      count_nxt = count_r - 2'd1;
      head_nxt  = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

>>> hw/rtl/word_wrap_row_breaker.sv
// ----------------------------------------------------------------------------
// word_wrap_row_breaker
// Greedy word wrap of one text line, one UTF-8 byte per request.
// ----------------------------------------------------------------------------
// Takes one byte request per clock while the result register can accept it. A
// request is held in an input register until the result register is free, the
// break decision is made in a single pass from there and its row starts land
// in a two-entry result register. A request normally yields zero or one row
// start and the block sustains one request per cycle while output ready is
// high; a break after a space followed by a forced break at the current byte
// yields two, which fill both entries and hold the input until the second is
// taken. Input ready follows output ready through result register occupancy.
module word_wrap_row_breaker (
  input  logic                         clk,
  input  logic                         rst_n,
  wwrb_in_if.sink                      in_chan,
  wwrb_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wwrb_pkg::PADDR_W-1:0] paddr,
  input  logic [wwrb_pkg::PDATA_W-1:0] pwdata,
  output logic [wwrb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import wwrb_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  res_t  res;
  logic  q_free;
  logic  core_ready;

  // configuration registers
  wwrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // break decision
  assign in_item.command    = in_chan.command;
  assign in_item.byte_value = in_chan.byte_value;
  assign in_chan.ready      = core_ready;

  wwrb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_chan.valid),
    .in_item  (in_item),
    .in_ready (core_ready),
    .q_free   (q_free),
    .res      (res)
  );

  // result register
  wwrb_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .res         (res),
    .q_free      (q_free),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .row_start   (out_chan.row_start),
    .last_of_run (out_chan.last_of_run)
  );

endmodule

>>> hw/rtl/wwrb_checker.sv
// ----------------------------------------------------------------------------
// wwrb_checker
// Port-level checks on the row breaker, bound to the top level.
// ----------------------------------------------------------------------------
`include "word_wrap_row_breaker_macros.svh"

module wwrb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [wwrb_pkg::OFF_W-1:0]   row_start,
  input logic                         last_of_run,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [wwrb_pkg::PADDR_W-1:0] paddr,
  input logic [wwrb_pkg::PDATA_W-1:0] pwdata,
  input logic [wwrb_pkg::PDATA_W-1:0] prdata
);
  import wwrb_pkg::*;

  // stalled result holds its payload
  `WWRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_start) && $stable(last_of_run), "result changed while stalled")

  // an empty result register never holds back the input
  `WWRB_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input stalled with no result pending")

  // the second row start of a pair follows straight after the first
  `WWRB_ASSERT_NEXT(a_pair_tail, out_valid && out_ready && !last_of_run, out_valid && last_of_run, "second row start of a pair missing")

  // row width reads back what was written
  `WWRB_ASSERT_NEXT(a_width_readback, psel && penable && pwrite && paddr[2], !paddr[2] || (prdata[ROWW_W-1:0] == $past(pwdata[ROWW_W-1:0])), "row width read back mismatch")

endmodule

bind word_wrap_row_breaker wwrb_checker u_wwrb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .row_start   (out_chan.row_start),
  .last_of_run (out_chan.last_of_run),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
